// ----- rtl/efh_pkg.sv -----
// Shared constants, types and mixing functions for the ECMP flow hash.
// No dependencies; imported by efh_finalize and ecmp_flow_hash.
package efh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  proto_t;
	typedef logic [15:0] port_t;

	localparam word_t MixC1   = 32'hcc9e2d51;
	localparam word_t MixC2   = 32'h1b873593;
	localparam word_t MixAdd  = 32'he6546b64;
	localparam word_t FinM1   = 32'h85ebca6b;
	localparam word_t FinM2   = 32'hc2b2ae35;
	localparam word_t KeyBytes = 32'd12;

	localparam proto_t ProtoTcp  = 8'h06;
	localparam proto_t ProtoUdp  = 8'h11;
	localparam proto_t ProtoAck  = 8'hFC;
	localparam proto_t ProtoNack = 8'hFD;

	function automatic word_t rotl(input word_t v, input int unsigned r);
		rotl = (v << r) | (v >> (32 - r));
	endfunction

	// Accumulator half of one block step: xor, rotate 13, times 5 plus constant.
	function automatic word_t mix_tail(input word_t acc, input word_t k);
		word_t a;
		a = rotl(acc ^ k, 13);
		mix_tail = (a << 2) + a + MixAdd;
	endfunction

	function automatic logic has_ports(input proto_t p);
		has_ports = (p == ProtoTcp) || (p == ProtoUdp) || (p == ProtoAck) ||
			(p == ProtoNack);
	endfunction

endpackage

// ----- rtl/efh_finalize.sv -----
// Three-stage MurmurHash3 finalizer with valid/stall flow control.
// Depends on efh_pkg.
module efh_finalize (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc_valid,
	output logic          acc_ready,
	input  efh_pkg::word_t acc,
	output logic          out_valid,
	input  logic          out_stall,
	output efh_pkg::word_t flow_hash
);
	import efh_pkg::*;

	logic  v_s6, v_s7, v_s8;
	logic  rdy_s6, rdy_s7, rdy_s8;
	word_t h_s6, h_s7, h_s8;
	word_t a6, a7, a8;

	assign rdy_s8 = !v_s8 || !out_stall;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign acc_ready = rdy_s6;

	always_comb begin
		a6 = acc ^ KeyBytes;
		a6 = a6 ^ (a6 >> 16);
		a7 = h_s6 ^ (h_s6 >> 13);
		a8 = h_s7 ^ (h_s7 >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s6) v_s6 <= acc_valid;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && acc_valid) h_s6 <= a6 * FinM1;
		if (rdy_s7 && v_s6)      h_s7 <= a7 * FinM2;
		if (rdy_s8 && v_s7)      h_s8 <= a8;
	end

	assign out_valid = v_s8;
	assign flow_hash = h_s8;

`ifndef SYNTHESIS
	a_hold_s8: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && out_stall |=> v_s8 && $stable(h_s8))
		else $error("finalizer output stage changed while held");
	a_adv_s7: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && rdy_s8 |=> v_s8)
		else $error("finalizer lost a word between stage 7 and 8");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_ready |-> v_s6 && v_s7 && v_s8 && out_stall)
		else $error("finalizer refused a word with room left");
`endif

endmodule

// ----- rtl/ecmp_flow_hash.sv -----
// Top level of the ECMP five-tuple flow hash (MurmurHash3 x86_32, 12-byte key).
// Depends on efh_pkg and efh_finalize.
//
// Usage:
//   Input channel: in_valid/in_stall with src_addr, dst_addr, ip_protocol,
//   src_port, dst_port. A word is taken at a clock edge with in_valid high
//   and in_stall low. The ports word is zero unless the protocol is TCP,
//   UDP, ACK or NACK.
//   Output channel: out_valid/out_stall with flow_hash, one result per word.
//   Config channel: cfg_valid/cfg_ready with hash_seed; cfg_ready is always
//   high. Write the seed only while no word is in flight.
//   Pipeline: eight register stages (two key-scramble multiply stages, three
//   accumulator stages, three finalizer stages) lie between input and output.
//   Throughput: one word per cycle while out_stall is low.
//   Stall: each stage holds while the next one is full and held; bubbles
//   close up, so input is stalled only once all eight stages are full and
//   out_stall is high. Nothing is dropped or repeated.
//   Reset: clears all stage valid bits and sets the seed to zero.
module ecmp_flow_hash (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  efh_pkg::word_t  src_addr,
	input  efh_pkg::word_t  dst_addr,
	input  efh_pkg::proto_t ip_protocol,
	input  efh_pkg::port_t  src_port,
	input  efh_pkg::port_t  dst_port,
	output logic            out_valid,
	input  logic            out_stall,
	output efh_pkg::word_t  flow_hash,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  efh_pkg::word_t  hash_seed
);
	import efh_pkg::*;

	word_t seed_q;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic  fin_rdy;
	word_t k_s1 [3];
	word_t k_s2 [3];
	word_t key_in [3];
	word_t k2_s3, k3_s3, k3_s4;
	word_t acc_s3, acc_s4, acc_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid) begin
			seed_q <= hash_seed;
		end
	end

	assign rdy_s5 = !v_s5 || fin_rdy;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_comb begin
		key_in[0] = src_addr;
		key_in[1] = dst_addr;
		key_in[2] = has_ports(ip_protocol) ? {dst_port, src_port} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Key scramble for all three blocks runs in parallel; accumulator chain follows.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (rdy_s1 && in_valid) k_s1[i] <= key_in[i] * MixC1;
			if (rdy_s2 && v_s1)     k_s2[i] <= rotl(k_s1[i], 15) * MixC2;
		end
		if (rdy_s3 && v_s2) begin
			acc_s3 <= mix_tail(seed_q, k_s2[0]);
			k2_s3  <= k_s2[1];
			k3_s3  <= k_s2[2];
		end
		if (rdy_s4 && v_s3) begin
			acc_s4 <= mix_tail(acc_s3, k2_s3);
			k3_s4  <= k3_s3;
		end
		if (rdy_s5 && v_s4) acc_s5 <= mix_tail(acc_s4, k3_s4);
	end

	efh_finalize u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (v_s5),
		.acc_ready (fin_rdy),
		.acc       (acc_s5),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flow_hash (flow_hash)
	);

`ifndef SYNTHESIS
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5)
		else $error("input stalled while the pipeline has a bubble");
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy_s4 |=> v_s3 && $stable(acc_s3) && $stable(k3_s3))
		else $error("stage 3 changed while held");
	a_adv_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && rdy_s2 |=> v_s2)
		else $error("word lost between stage 1 and 2");
	a_take_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !v_s4 && rdy_s5 |=> !v_s5)
		else $error("stage 5 repeated a word");
`endif

endmodule
